[hw/rtl/lls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lls_pkg
// Shared types and constants of the lexical scanner: scan modes, token kinds,
// error codes, character codes and the keyword table.
// ----------------------------------------------------------------------------
package lls_pkg;

   // Scan modes kept between source bytes.
   typedef enum logic [3:0] {
      MODE_IDLE, MODE_BANG, MODE_EQ, MODE_LESS, MODE_GREATER, MODE_SLASH,
      MODE_COMMENT, MODE_STRING, MODE_NUMBER, MODE_NUMDOT, MODE_FRACTION,
      MODE_IDENT
   } scan_mode_type;

   // Token kinds.
   localparam logic [5:0] TK_LPAREN    = 6'd0;
   localparam logic [5:0] TK_RPAREN    = 6'd1;
   localparam logic [5:0] TK_LBRACE    = 6'd2;
   localparam logic [5:0] TK_RBRACE    = 6'd3;
   localparam logic [5:0] TK_COMMA     = 6'd4;
   localparam logic [5:0] TK_DOT       = 6'd5;
   localparam logic [5:0] TK_MINUS     = 6'd6;
   localparam logic [5:0] TK_PLUS      = 6'd7;
   localparam logic [5:0] TK_SEMICOLON = 6'd8;
   localparam logic [5:0] TK_STAR      = 6'd9;
   localparam logic [5:0] TK_BANG      = 6'd10;
   localparam logic [5:0] TK_EQUAL     = 6'd12;
   localparam logic [5:0] TK_LESS      = 6'd14;
   localparam logic [5:0] TK_GREATER   = 6'd16;
   localparam logic [5:0] TK_SLASH     = 6'd18;
   localparam logic [5:0] TK_STRING    = 6'd19;
   localparam logic [5:0] TK_NUMBER    = 6'd20;
   localparam logic [5:0] TK_IDENT     = 6'd21;
   localparam logic [5:0] TK_KW_FIRST  = 6'd22;

   // Error codes.
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [1:0] ERR_UNTERM     = 2'd2;

   // Character codes.
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACE  = 8'h7b;
   localparam logic [7:0] CH_RBRACE  = 8'h7d;
   localparam logic [7:0] CH_COMMA   = 8'h2c;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_SEMI    = 8'h3b;
   localparam logic [7:0] CH_STAR    = 8'h2a;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_EQUAL   = 8'h3d;
   localparam logic [7:0] CH_LESS    = 8'h3c;
   localparam logic [7:0] CH_GREATER = 8'h3e;
   localparam logic [7:0] CH_SLASH   = 8'h2f;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NL      = 8'h0a;
   localparam logic [7:0] CH_QUOTE   = 8'h22;

   // Keyword table, first character in the low byte, zero padded.
   localparam int KW_COUNT = 16;
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      48'h000000646e61, 48'h007373616c63, 48'h000065736c65, 48'h0065736c6166,
      48'h000000726f66, 48'h0000006e7566, 48'h000000006669, 48'h0000006c696e,
      48'h00000000726f, 48'h00746e697270, 48'h6e7275746572, 48'h007265707573,
      48'h000073696874, 48'h000065757274, 48'h000000726176, 48'h00656c696877
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd5, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd3,
      4'd2, 4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5
   };

   // One result beat as it leaves the block.
   typedef struct packed {
      logic        last;
      logic [23:0] lexeme_length;
      logic [23:0] start_offset;
      logic [19:0] line_number;
      logic [1:0]  error_code;
      logic [5:0]  token_kind;
   } rsp_beat_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
             (c == 8'h5f);
   endfunction

endpackage

[hw/rtl/lox_lexical_scanner.sv]
`timescale 1ns / 1ps
// Results of a beat are registered in the result queue and leave from its head.
// Throughput: one source byte per cycle while each byte yields at most one
// result and rsp_tready stays high; a byte that yields two or three results
// holds the input back until the single-beat output port of the four-entry
// result queue drains it. Reset: synchronous and active high; mode idle,
// offsets zero, line one, queue empty.
// ----------------------------------------------------------------------------
// lox_lexical_scanner
// Streaming tokenizer: one source byte per input beat, end of input flagged
// in tuser. Finished tokens leave as kind, error, line, start and length.
// ----------------------------------------------------------------------------
module lox_lexical_scanner #(
   parameter int OFFSET_BITS = 24,
   parameter int LINE_BITS   = 20,
   parameter int KEYWORD_MAX = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [5:0] token_kind, [7:6] error_code, [27:8] line_number,
   // [51:28] start_offset, [75:52] lexeme_length, [79:76] zero
   output logic [79:0] rsp_tdata,
   output logic        rsp_tlast
);
   import lls_pkg::*;

   localparam int CNT_W = $clog2(KEYWORD_MAX + 2);
   localparam int PRE_W = 8 * KEYWORD_MAX;

   typedef logic [OFFSET_BITS-1:0] off_type;
   typedef logic [LINE_BITS-1:0]   line_type;

   scan_mode_type    mode_ff, mode_in;
   off_type          start_ff, start_in;
   off_type          offset_ff, offset_in;
   off_type          length_ff, length_in;
   line_type         line_ff, line_in;
   logic [PRE_W-1:0] prefix_ff, prefix_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic         accept, eoi, room_ok;
   logic [7:0]   ch;
   logic         do_finish, do_disp, direct, line_inc;
   logic         a_v, b_v, c_v;
   logic [5:0]   a_kind, c_kind, fin_kind, word_kind;
   logic [1:0]   a_err, c_err;
   off_type      a_start, a_len, b_start, c_start;
   logic [1:0]   push_count;
   rsp_beat_type beat_a, beat_b, beat_c, head_beat;
   rsp_beat_type push_beat [3];

   function automatic off_type off_add(input off_type x, input off_type y);
      logic [OFFSET_BITS:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[OFFSET_BITS] ? '1 : s[OFFSET_BITS-1:0];
   endfunction

   function automatic rsp_beat_type make_beat(input logic [5:0] kind,
      input logic [1:0] err, input line_type line, input off_type start,
      input off_type len, input logic last);
      rsp_beat_type b;
      b.last          = last;
      b.lexeme_length = 24'(len);
      b.start_offset  = 24'(start);
      b.line_number   = 20'(line);
      b.error_code    = err;
      b.token_kind    = kind;
      return b;
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = room_ok;
   assign eoi        = req_tuser;
   assign ch         = req_tdata;

   // Keyword match on the stored word prefix.
   always_comb begin
      word_kind = TK_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if ((4'(count_ff) == KW_LEN[k]) && (prefix_ff[47:0] == KW_TEXT[k])) begin
            word_kind = TK_KW_FIRST + 6'(k);
         end
      end
   end

   // Next-state decode per byte or end of input.
   always_comb begin
      mode_in   = mode_ff;
      start_in  = start_ff;
      offset_in = offset_ff;
      length_in = length_ff;
      prefix_in = prefix_ff;
      count_in  = count_ff;
      do_finish = 1'b0;
      do_disp   = 1'b0;
      direct    = 1'b0;
      line_inc  = 1'b0;
      if (eoi) begin
         do_finish = 1'b1;
         mode_in   = MODE_IDLE;
      end else begin
         offset_in = off_add(offset_ff, off_type'(1));
         unique case (mode_ff)
            MODE_BANG, MODE_EQ, MODE_LESS, MODE_GREATER: begin
               if (ch == CH_EQUAL) begin
                  direct  = 1'b1;
                  mode_in = MODE_IDLE;
               end else begin
                  do_finish = 1'b1;
                  do_disp   = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (ch == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  do_finish = 1'b1;
                  do_disp   = 1'b1;
               end
            end
            MODE_COMMENT: begin
               do_disp = (ch == CH_NL);
            end
            MODE_STRING: begin
               length_in = off_add(length_ff, off_type'(1));
               if (ch == CH_QUOTE) begin
                  direct  = 1'b1;
                  mode_in = MODE_IDLE;
               end else begin
                  line_inc = (ch == CH_NL);
               end
            end
            MODE_NUMBER: begin
               if (is_digit(ch)) begin
                  length_in = off_add(length_ff, off_type'(1));
               end else if (ch == CH_DOT) begin
                  mode_in = MODE_NUMDOT;
               end else begin
                  do_finish = 1'b1;
                  do_disp   = 1'b1;
               end
            end
            MODE_NUMDOT: begin
               if (is_digit(ch)) begin
                  length_in = off_add(length_ff, off_type'(2));
                  mode_in   = MODE_FRACTION;
               end else begin
                  do_finish = 1'b1;
                  do_disp   = 1'b1;
               end
            end
            MODE_FRACTION: begin
               if (is_digit(ch)) begin
                  length_in = off_add(length_ff, off_type'(1));
               end else begin
                  do_finish = 1'b1;
                  do_disp   = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_alpha(ch) || is_digit(ch)) begin
                  length_in = off_add(length_ff, off_type'(1));
                  for (int i = 0; i < KEYWORD_MAX; i++) begin
                     if (count_ff == CNT_W'(i)) begin
                        prefix_in[8*i +: 8] = ch;
                     end
                  end
                  if (count_ff <= CNT_W'(KEYWORD_MAX)) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  do_finish = 1'b1;
                  do_disp   = 1'b1;
               end
            end
            default: begin
               do_disp = 1'b1;
            end
         endcase
      end

      // A fresh token starts with this byte.
      if (do_disp) begin
         mode_in   = MODE_IDLE;
         start_in  = offset_ff;
         length_in = off_type'(1);
         priority case (1'b1)
            (ch == CH_BANG):    mode_in = MODE_BANG;
            (ch == CH_EQUAL):   mode_in = MODE_EQ;
            (ch == CH_LESS):    mode_in = MODE_LESS;
            (ch == CH_GREATER): mode_in = MODE_GREATER;
            (ch == CH_SLASH):   mode_in = MODE_SLASH;
            (ch == CH_QUOTE):   mode_in = MODE_STRING;
            (ch == CH_NL):      line_inc = 1'b1;
            is_digit(ch):       mode_in = MODE_NUMBER;
            is_alpha(ch): begin
               mode_in   = MODE_IDENT;
               prefix_in = '0;
               prefix_in[7:0] = ch;
               count_in  = CNT_W'(1);
            end
            default: begin
            end
         endcase
      end

      line_in = (line_inc && (line_ff != '1)) ? line_ff + line_type'(1) : line_ff;
   end

   // Results of closing the pending token, or of a direct match: a two-byte operator or a closed string.
   always_comb begin
      fin_kind = TK_IDENT;
      a_v      = 1'b0;
      b_v      = 1'b0;
      a_err    = ERR_NONE;
      a_start  = start_ff;
      a_len    = length_ff;
      b_start  = off_add(start_ff, length_ff);
      unique case (mode_ff)
         MODE_BANG:    fin_kind = TK_BANG;
         MODE_EQ:      fin_kind = TK_EQUAL;
         MODE_LESS:    fin_kind = TK_LESS;
         MODE_GREATER: fin_kind = TK_GREATER;
         MODE_SLASH:   fin_kind = TK_SLASH;
         MODE_STRING:  fin_kind = TK_STRING;
         MODE_NUMBER, MODE_NUMDOT, MODE_FRACTION: fin_kind = TK_NUMBER;
         default:      fin_kind = word_kind;
      endcase
      a_kind = fin_kind;
      if (direct) begin
         a_v = 1'b1;
         if (mode_ff == MODE_STRING) begin
            a_len = length_in;
         end else begin
            a_kind = fin_kind + 6'd1;
            a_len  = off_type'(2);
         end
      end else if (do_finish) begin
         a_v = (mode_ff != MODE_IDLE) && (mode_ff != MODE_COMMENT);
         b_v = (mode_ff == MODE_NUMDOT);
         if (mode_ff == MODE_STRING) begin
            a_err = ERR_UNTERM;
         end
         if ((mode_ff == MODE_BANG) || (mode_ff == MODE_EQ) ||
             (mode_ff == MODE_LESS) || (mode_ff == MODE_GREATER) ||
             (mode_ff == MODE_SLASH)) begin
            a_len = off_type'(1);
         end
      end
   end

   // Single-byte tokens and unexpected characters from the fresh byte.
   always_comb begin
      c_v     = do_disp;
      c_err   = ERR_NONE;
      c_kind  = TK_LPAREN;
      c_start = offset_ff;
      unique case (ch)
         CH_LPAREN: c_kind = TK_LPAREN;
         CH_RPAREN: c_kind = TK_RPAREN;
         CH_LBRACE: c_kind = TK_LBRACE;
         CH_RBRACE: c_kind = TK_RBRACE;
         CH_COMMA:  c_kind = TK_COMMA;
         CH_DOT:    c_kind = TK_DOT;
         CH_MINUS:  c_kind = TK_MINUS;
         CH_PLUS:   c_kind = TK_PLUS;
         CH_SEMI:   c_kind = TK_SEMICOLON;
         CH_STAR:   c_kind = TK_STAR;
         CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER, CH_SLASH, CH_QUOTE,
         CH_SPACE, CH_CR, CH_TAB, CH_NL: c_v = 1'b0;
         default: begin
            if (is_digit(ch) || is_alpha(ch)) begin
               c_v = 1'b0;
            end else begin
               c_err = ERR_UNEXPECTED;
            end
         end
      endcase
   end

   // Pack the results in order and mark the last one.
   always_comb begin
      beat_a = make_beat(a_kind, a_err, line_ff, a_start, a_len, !b_v && !c_v);
      beat_b = make_beat(TK_DOT, ERR_NONE, line_ff, b_start, off_type'(1), !c_v);
      beat_c = make_beat(c_kind, c_err, line_ff, c_start, off_type'(1), 1'b1);
      push_beat[0] = a_v ? beat_a : beat_c;
      push_beat[1] = b_v ? beat_b : beat_c;
      push_beat[2] = beat_c;
      push_count   = accept ? (2'(a_v) + 2'(b_v) + 2'(c_v)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         start_ff  <= '0;
         offset_ff <= '0;
         length_ff <= '0;
         line_ff   <= line_type'(1);
         prefix_ff <= '0;
         count_ff  <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
         line_ff   <= line_in;
         prefix_ff <= prefix_in;
         count_ff  <= count_in;
      end
   end

   lls_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_beat  (push_beat),
      .room_ok    (room_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head_beat  (head_beat)
   );

   assign rsp_tdata = {4'd0, head_beat.lexeme_length, head_beat.start_offset,
                       head_beat.line_number, head_beat.error_code,
                       head_beat.token_kind};
   assign rsp_tlast = head_beat.last;

endmodule

[hw/rtl/lls_rsp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lls_rsp_queue
// Four-entry result queue that takes up to three beats in one cycle and
// hands out one beat per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module lls_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  lls_pkg::rsp_beat_type push_beat [3],
   output logic                  room_ok,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output lls_pkg::rsp_beat_type head_beat
);
   import lls_pkg::*;

   rsp_beat_type entry_ff [4];
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [2:0]   count_ff, count_in;
   logic         pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != 3'd0);
   assign head_beat  = entry_ff[rd_ptr_ff];
   // Three free entries are needed before an item may enter.
   assign room_ok    = (count_ff <= 3'd1);

   // Pointer and fill bookkeeping.
   always_comb begin
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      wr_ptr_in = wr_ptr_ff + push_count;
      count_in  = count_ff + 3'(push_count) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Beat storage.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push_count) begin
            entry_ff[wr_ptr_ff + 2'(i)] <= push_beat[i];
         end
      end
   end

endmodule

[hw/rtl/lls_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lls_checker
// Port-level checks on the scanner's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lls_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   // The result queue is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat shown right after reset");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // Error code three is never produced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:6] != 2'd3)
      else $error("undefined error code");

   // The line count starts at one and never wraps to zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[27:8] != 20'd0)
      else $error("line number zero");

endmodule

bind lox_lexical_scanner lls_checker u_lls_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
